FILE: design/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and helpers for the sorted keyed table
// Request/response payloads, table record layout, opcodes, status codes,
// identifier normalization and sort key selection.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned ID_CHARS_DEF = 6;
  localparam int unsigned ID_MAX_CHARS = 6;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned PLATE_W      = ID_MAX_CHARS * CHAR_W;
  localparam int unsigned MILE_W       = 24;
  localparam int unsigned DATE_W       = 20;
  localparam int unsigned COUNT_W      = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [PLATE_W-1:0] plate_chars;
    logic [MILE_W-1:0]  mileage_in;
    logic [DATE_W-1:0]  date_in;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PLATE_W-1:0] plate_out;
    logic [MILE_W-1:0]  mileage_out;
    logic [DATE_W-1:0]  date_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [PLATE_W-1:0] plate;
    logic [MILE_W-1:0]  mileage;
    logic [DATE_W-1:0]  date;
  } entry_t;

  // cut at first NUL and after keep chars, fold A-Z to lower case
  function automatic logic [PLATE_W-1:0] normalize_id(logic [PLATE_W-1:0] raw,
                                                      int unsigned keep);
    logic [PLATE_W-1:0] res;
    logic               alive;
    logic [CHAR_W-1:0]  c;
    res   = '0;
    alive = 1'b1;
    for (int unsigned i = 0; i < ID_MAX_CHARS; i++) begin
      c = raw[PLATE_W-1-CHAR_W*i -: CHAR_W];
      if (i >= keep || c == '0) begin
        alive = 1'b0;
      end
      if (alive) begin
        if (c inside {[8'h41:8'h5A]}) begin
          c = c + 8'h20;
        end
        res[PLATE_W-1-CHAR_W*i -: CHAR_W] = c;
      end
    end
    return res;
  endfunction

  function automatic logic [MILE_W-1:0] key_of(entry_t e, logic by_date);
    return by_date ? MILE_W'(e.date) : e.mileage;
  endfunction

endpackage

`default_nettype wire

FILE: design/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/sorted_keyed_table_top.sv
// ----------------------------------------------------------------------------
// sorted_keyed_table_top: bounded table of records kept sorted by one key
// Insert in key order, look up / remove by identifier, remove front entry.
// ----------------------------------------------------------------------------
// One request at a time. A request walks the table through the RAM read port
// one entry per cycle until its position or match is found, then an insert or
// remove shifts the entries behind it one per cycle, reusing the same port
// pair. A refused insert into a full table goes straight to the result. The
// result is held in an output register, so a new request is taken while a
// result waits. The sort key register only affects later inserts; the
// existing order is kept.
`default_nettype none

module sorted_keyed_table_top #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF,
  parameter int unsigned ID_CHARS = skt_pkg::ID_CHARS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          req_valid_i,
  output logic               req_stall_o,
  input  wire skt_pkg::req_t req_i,
  output logic               rsp_valid_o,
  input  wire logic          rsp_stall_i,
  output skt_pkg::rsp_t      rsp_o
);

  import skt_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned KEEP = (ID_CHARS < ID_MAX_CHARS) ? ID_CHARS : ID_MAX_CHARS;
  localparam int unsigned EW   = $bits(entry_t);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_e        state_q, state_d;
  logic          sort_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] chk_idx_q, chk_idx_d;
  logic          chk_v_q, chk_v_d;
  logic [CW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_v_q, wr_v_d;
  op_e           op_q, op_d;
  entry_t        nent_q, nent_d;
  entry_t        res_q, res_d;
  status_e       stat_q, stat_d;
  logic          rsp_valid_q, rsp_valid_d;
  rsp_t          rsp_q, rsp_d;

  logic          ram_we, ram_re;
  logic [CW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_ent;
  logic          hit;
  logic [MILE_W-1:0] rd_key, new_key;

  skt_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr[AW-1:0]),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_ent  = entry_t'(ram_rdata);
  assign rd_key  = key_of(rd_ent, sort_q);
  assign new_key = key_of(nent_q, sort_q);

  always_comb begin
    case (op_q)
      OP_INSERT: hit = (chk_idx_q == '0) ? (rd_key > new_key) : (rd_key >= new_key);
      OP_LOOKUP,
      OP_REMOVE: hit = (rd_ent.plate == nent_q.plate);
      OP_POP:    hit = 1'b1;
      default:   hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sort_q      <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      chk_v_q     <= 1'b0;
      wr_v_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        sort_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      chk_v_q     <= chk_v_d;
      wr_v_q      <= wr_v_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    chk_idx_q <= chk_idx_d;
    wr_addr_q <= wr_addr_d;
    op_q      <= op_d;
    nent_q    <= nent_d;
    res_q     <= res_d;
    stat_q    <= stat_d;
    rsp_q     <= rsp_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    chk_idx_d   = chk_idx_q;
    chk_v_d     = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_v_d      = 1'b0;
    op_d        = op_q;
    nent_d      = nent_q;
    res_d       = res_q;
    stat_d      = stat_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q && rsp_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = wr_addr_q;
    ram_wdata   = rd_ent;
    ram_re      = 1'b0;
    ram_raddr   = idx_q;
    req_stall_o = 1'b1;

    case (state_q)
      ST_IDLE: begin
        req_stall_o = 1'b0;
        if (req_valid_i) begin
          op_d          = req_i.op;
          nent_d.plate  = normalize_id(req_i.plate_chars, KEEP);
          nent_d.mileage = req_i.mileage_in;
          nent_d.date   = req_i.date_in;
          res_d         = '0;
          stat_d        = STAT_MISS;
          idx_d         = '0;
          if (req_i.op == OP_INSERT && cnt_q == CAP) begin
            stat_d  = STAT_FULL;
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (chk_v_q && hit) begin
          case (op_q)
            OP_INSERT: begin
              pos_d   = chk_idx_q;
              idx_d   = cnt_q;
              state_d = ST_SHIFT_DN;
            end
            OP_LOOKUP: begin
              stat_d  = STAT_OK;
              res_d   = rd_ent;
              state_d = ST_DONE;
            end
            default: begin
              stat_d  = STAT_OK;
              res_d   = rd_ent;
              idx_d   = chk_idx_q + CW'(1);
              state_d = ST_SHIFT_UP;
            end
          endcase
        end else if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          chk_v_d   = 1'b1;
          chk_idx_d = idx_q;
          idx_d     = idx_q + CW'(1);
        end else if (!chk_v_q) begin
          if (op_q == OP_INSERT) begin
            pos_d   = cnt_q;
            idx_d   = cnt_q;
            state_d = ST_SHIFT_DN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // idx_q is the destination slot still to be filled from idx_q-1
      ST_SHIFT_DN: begin
        if (wr_v_q) begin
          ram_we = 1'b1;
        end
        if (idx_q > pos_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q - CW'(1);
          wr_addr_d = idx_q;
          wr_v_d    = 1'b1;
          idx_d     = idx_q - CW'(1);
        end else if (!wr_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q;
          ram_wdata = nent_q;
          stat_d    = STAT_OK;
          res_d     = nent_q;
          cnt_d     = cnt_q + CW'(1);
          state_d   = ST_DONE;
        end
      end

      // idx_q is the source slot moved to idx_q-1
      ST_SHIFT_UP: begin
        if (wr_v_q) begin
          ram_we = 1'b1;
        end
        if (idx_q < cnt_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          wr_addr_d = idx_q - CW'(1);
          wr_v_d    = 1'b1;
          idx_d     = idx_q + CW'(1);
        end else if (!wr_v_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || !rsp_stall_i) begin
          rsp_d.status      = stat_q;
          rsp_d.plate_out   = res_q.plate;
          rsp_d.mileage_out = res_q.mileage;
          rsp_d.date_out    = res_q.date;
          rsp_d.entry_count = COUNT_W'(cnt_q);
          rsp_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

FILE: design/skt_chk.sv
// ----------------------------------------------------------------------------
// skt_chk: port-level checks for the sorted keyed table
// Observes the request/response channels and flags inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_chk #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          req_valid_i,
  input wire logic          req_stall_o,
  input wire logic          rsp_valid_o,
  input wire logic          rsp_stall_i,
  input wire skt_pkg::rsp_t rsp_o
);

  import skt_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  // a taken request keeps the block busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> req_stall_o)
    else $error("request accepted while previous one still running");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == STAT_FULL) |-> (rsp_o.entry_count == CAP_CNT))
    else $error("full status with table not full");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == STAT_MISS || rsp_o.status == STAT_FULL)) |->
    (rsp_o.plate_out == '0 && rsp_o.mileage_out == '0 && rsp_o.date_out == '0))
    else $error("refused or missed request carries record data");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_stall_i) |=> (rsp_valid_o && $stable(rsp_o)))
    else $error("stalled response changed");

endmodule

bind sorted_keyed_table_top skt_chk #(
  .CAPACITY(CAPACITY)
) u_skt_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_stall_o(req_stall_o),
  .rsp_valid_o(rsp_valid_o),
  .rsp_stall_i(rsp_stall_i),
  .rsp_o      (rsp_o)
);

`default_nettype wire
